// ----- sv/imwd_pkg.sv -----
// Shared widths, register codes, reset values and types for the impact detector.
`timescale 1ns / 1ps
`default_nettype none
package imwd_pkg;

    localparam int MAG_W     = 21;
    localparam int ALPHA_W   = 16;
    localparam int WIN_W     = 16;
    localparam int ID_W      = 8;
    localparam int CFG_W     = 21;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE    = 2'd3;

    localparam logic [ALPHA_W-1:0] RST_ALPHA     = 16'd28830;
    localparam logic [MAG_W-1:0]   RST_THRESHOLD = 21'd261224;
    localparam logic [WIN_W-1:0]   RST_WINDOW    = 16'd200;
    localparam logic [ID_W-1:0]    RST_DEVICE    = 8'd3;

    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

    // sample queue between front and back end
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic [ALPHA_W-1:0] alpha;
        logic [MAG_W-1:0]   threshold;
        logic [WIN_W-1:0]   window;
        logic [ID_W-1:0]    device;
    } t_cfg;

endpackage
`default_nettype wire

// ----- sv/imwd_sample_if.sv -----
// Valid/ready channel carrying one three-axis accelerometer sample.
`timescale 1ns / 1ps
`default_nettype none
interface imwd_sample_if #(
    parameter int SAMPLE_BITS = 13
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface
`default_nettype wire

// ----- sv/imwd_report_if.sv -----
// Valid/ready channel carrying one window report.
`timescale 1ns / 1ps
`default_nettype none
interface imwd_report_if;
    logic                       valid;
    logic                       ready;
    logic [imwd_pkg::MAG_W-1:0] peak_magnitude;
    logic                       impact_flag;
    logic [imwd_pkg::ID_W-1:0]  source_id;

    modport source (output valid, output peak_magnitude, output impact_flag,
                    output source_id, input ready);
    modport sink   (input valid, input peak_magnitude, input impact_flag,
                    input source_id, output ready);
endinterface
`default_nettype wire

// ----- sv/imwd_front.sv -----
// Front end: accepts samples, squares the axes and pushes the sum of squares.
`timescale 1ns / 1ps
`default_nettype none
module imwd_front #(
    parameter int SAMPLE_BITS = 13
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    imwd_sample_if.sink                   i_sample,
    input  wire logic                     i_full,
    output logic                          o_push,
    output logic [2*SAMPLE_BITS-1:0]      o_sum
);
    localparam int SQ_W  = 2*SAMPLE_BITS - 1;
    localparam int SUM_W = 2*SAMPLE_BITS;

    logic signed [2*SAMPLE_BITS-1:0] prod_x, prod_y, prod_z;
    logic [SQ_W-1:0] r_sq_x, r_sq_y, r_sq_z;
    logic            r_sq_vld, n_sq_vld;
    logic            accept;

    assign prod_x = i_sample.accel_x * i_sample.accel_x;
    assign prod_y = i_sample.accel_y * i_sample.accel_y;
    assign prod_z = i_sample.accel_z * i_sample.accel_z;

    assign o_push         = r_sq_vld && !i_full;
    assign i_sample.ready = !r_sq_vld || !i_full;
    assign accept         = i_sample.valid && i_sample.ready;
    assign o_sum          = SUM_W'(r_sq_x) + SUM_W'(r_sq_y) + SUM_W'(r_sq_z);

    always_comb begin
        n_sq_vld = r_sq_vld;
        if (accept) begin
            n_sq_vld = 1'b1;
        end else if (o_push) begin
            n_sq_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld <= 1'b0;
        end else begin
            r_sq_vld <= n_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sq_x <= prod_x[SQ_W-1:0];
            r_sq_y <= prod_y[SQ_W-1:0];
            r_sq_z <= prod_z[SQ_W-1:0];
        end
    end
endmodule
`default_nettype wire

// ----- sv/imwd_fifo.sv -----
// Short register queue between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module imwd_fifo #(
    parameter int DATA_W = 26
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    input  wire logic              i_pop,
    output logic                   o_full,
    output logic                   o_empty,
    output logic [DATA_W-1:0]      o_data
);
    logic [DATA_W-1:0] r_mem [imwd_pkg::QUEUE_DEPTH];
    logic [imwd_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [imwd_pkg::QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (imwd_pkg::QPTR_W+1)'(imwd_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule
`default_nettype wire

// ----- sv/imwd_back.sv -----
// Back end: bit-serial square root, IIR low-pass, threshold and window report.
`timescale 1ns / 1ps
`default_nettype none
module imwd_back #(
    parameter int SAMPLE_BITS = 13,
    parameter int FRAC_BITS   = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire imwd_pkg::t_cfg           i_cfg,
    input  wire logic                     i_empty,
    input  wire logic [2*SAMPLE_BITS-1:0] i_sum,
    output logic                          o_pop,
    imwd_report_if.source                 o_report
);
    localparam int MAG_W  = imwd_pkg::MAG_W;
    localparam int RAD_W  = 2*SAMPLE_BITS + 2*FRAC_BITS;
    localparam int ROOT_W = SAMPLE_BITS + FRAC_BITS;
    localparam int IT_W   = $clog2(ROOT_W);
    localparam int EXT_W  = (ROOT_W > MAG_W) ? ROOT_W : MAG_W;
    localparam int PROD_W = MAG_W + imwd_pkg::ALPHA_W;
    localparam int ACC_W  = MAG_W + imwd_pkg::ALPHA_W + 2;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ROOT = 3'd1;
    localparam logic [2:0] ST_MUL1 = 3'd2;
    localparam logic [2:0] ST_MUL2 = 3'd3;
    localparam logic [2:0] ST_UPD  = 3'd4;

    logic [2:0]                  r_state, n_state;
    logic [RAD_W-1:0]            r_rad;
    logic [ROOT_W+1:0]           r_rem;
    logic [ROOT_W-1:0]           r_root;
    logic [IT_W-1:0]             r_iter;
    logic [PROD_W-1:0]           r_prod;
    logic [ACC_W-1:0]            r_acc;
    logic [MAG_W-1:0]            r_filt, r_peak;
    logic                        r_latch;
    logic [imwd_pkg::WIN_W-1:0]  r_count;
    logic                        r_out_vld;
    logic [MAG_W-1:0]            r_out_peak;
    logic                        r_out_flag;
    logic [imwd_pkg::ID_W-1:0]   r_out_id;

    logic [ROOT_W+1:0]           rem_sh, trial;
    logic                        take;
    logic [EXT_W-1:0]            root_ext;
    logic [MAG_W-1:0]            mag;
    logic [imwd_pkg::ALPHA_W:0]  beta;
    logic [MAG_W-1:0]            filt_new, peak_new;
    logic                        latch_new;
    logic [imwd_pkg::WIN_W:0]    count_nxt;
    logic                        win_end, out_free, commit, emit;

    // one root bit per cycle, two radicand bits shifted in
    assign rem_sh = {r_rem[ROOT_W-1:0], r_rad[RAD_W-1 -: 2]};
    assign trial  = {r_root, 2'b01};
    assign take   = (rem_sh >= trial);

    assign root_ext = EXT_W'(r_root);
    assign mag      = (root_ext > EXT_W'(imwd_pkg::MAG_MAX)) ? imwd_pkg::MAG_MAX
                                                              : root_ext[MAG_W-1:0];
    assign beta     = (imwd_pkg::ALPHA_W+1)'(1 << imwd_pkg::ALPHA_W) - {1'b0, i_cfg.alpha};

    assign filt_new  = r_acc[imwd_pkg::ALPHA_W +: MAG_W];
    assign latch_new = r_latch || (filt_new > i_cfg.threshold);
    assign peak_new  = (filt_new > r_peak) ? filt_new : r_peak;
    assign count_nxt = {1'b0, r_count} + 1'b1;
    assign win_end   = (count_nxt >= {1'b0, i_cfg.window});
    assign out_free  = !r_out_vld || o_report.ready;
    assign commit    = (r_state == ST_UPD) && (!win_end || out_free);
    assign emit      = commit && win_end;
    assign o_pop     = (r_state == ST_IDLE) && !i_empty;

    assign o_report.valid          = r_out_vld;
    assign o_report.peak_magnitude = r_out_peak;
    assign o_report.impact_flag    = r_out_flag;
    assign o_report.source_id      = r_out_id;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    n_state = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (r_iter == IT_W'(ROOT_W-1)) begin
                    n_state = ST_MUL1;
                end
            end
            ST_MUL1: n_state = ST_MUL2;
            ST_MUL2: n_state = ST_UPD;
            ST_UPD: begin
                if (commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_filt    <= '0;
            r_peak    <= '0;
            r_latch   <= 1'b0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_filt <= filt_new;
                if (win_end) begin
                    r_peak  <= '0;
                    r_latch <= 1'b0;
                    r_count <= '0;
                end else begin
                    r_peak  <= peak_new;
                    r_latch <= latch_new;
                    r_count <= count_nxt[imwd_pkg::WIN_W-1:0];
                end
            end
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (o_report.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rad  <= RAD_W'(i_sum) << (2*FRAC_BITS);
            r_rem  <= '0;
            r_root <= '0;
            r_iter <= '0;
        end
        if (r_state == ST_ROOT) begin
            r_rad  <= r_rad << 2;
            r_rem  <= take ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[ROOT_W-2:0], take};
            r_iter <= r_iter + 1'b1;
        end
        if (r_state == ST_MUL1) begin
            r_prod <= PROD_W'(i_cfg.alpha) * PROD_W'(mag);
        end
        if (r_state == ST_MUL2) begin
            r_acc <= ACC_W'(r_prod) + ACC_W'(beta) * ACC_W'(r_filt)
                   + ACC_W'(1 << (imwd_pkg::ALPHA_W-1));
        end
        if (emit) begin
            r_out_peak <= peak_new;
            r_out_flag <= latch_new;
            r_out_id   <= i_cfg.device;
        end
    end
endmodule
`default_nettype wire

// ----- sv/impact_magnitude_window_detector.sv -----
// Top level: configuration registers, front end, sample queue and back end.
// Takes three-axis accelerometer samples, forms the vector magnitude with
// FRAC_BITS fraction bits, smooths it with a Q0.16 first-order low-pass and
// reports, once per window of window_samples samples (0 acts as 1), the peak
// filtered magnitude and whether any filtered value went strictly over
// impact_threshold. The filter state carries across windows. Each sample
// passes through the back end's idle, root, multiply and update states; the
// bit-serial square root yields one result bit per cycle. The front end
// takes a sample per cycle until its four-entry queue fills. A finished
// report waits in an output register while the next samples are processed.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data; the
// user must do so only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module impact_magnitude_window_detector #(
    parameter int SAMPLE_BITS = 13,
    parameter int FRAC_BITS   = 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    imwd_sample_if.sink                         i_sample,
    imwd_report_if.source                       o_report,
    input  wire logic                           i_cfg_we,
    input  wire logic [imwd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [imwd_pkg::CFG_W-1:0]     i_cfg_data
);
    localparam int SUM_W = 2*SAMPLE_BITS;

    imwd_pkg::t_cfg r_cfg;

    logic             push, pop, full, empty;
    logic [SUM_W-1:0] front_sum, queue_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alpha     <= imwd_pkg::RST_ALPHA;
            r_cfg.threshold <= imwd_pkg::RST_THRESHOLD;
            r_cfg.window    <= imwd_pkg::RST_WINDOW;
            r_cfg.device    <= imwd_pkg::RST_DEVICE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                imwd_pkg::CFG_ALPHA:     r_cfg.alpha     <= i_cfg_data[imwd_pkg::ALPHA_W-1:0];
                imwd_pkg::CFG_THRESHOLD: r_cfg.threshold <= i_cfg_data[imwd_pkg::MAG_W-1:0];
                imwd_pkg::CFG_WINDOW:    r_cfg.window    <= i_cfg_data[imwd_pkg::WIN_W-1:0];
                imwd_pkg::CFG_DEVICE:    r_cfg.device    <= i_cfg_data[imwd_pkg::ID_W-1:0];
                default: ;
            endcase
        end
    end

    imwd_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (i_sample),
        .i_full   (full),
        .o_push   (push),
        .o_sum    (front_sum)
    );

    imwd_fifo #(.DATA_W(SUM_W)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_sum),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_data  (queue_sum)
    );

    imwd_back #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_empty  (empty),
        .i_sum    (queue_sum),
        .o_pop    (pop),
        .o_report (o_report)
    );
endmodule
`default_nettype wire

// ----- sv/imwd_checker.sv -----
// Port-level assertions for the impact detector, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module imwd_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_ready,
    input wire logic                       i_out_valid,
    input wire logic                       i_out_ready,
    input wire logic [imwd_pkg::MAG_W-1:0] i_out_peak,
    input wire logic                       i_out_flag,
    input wire logic [imwd_pkg::ID_W-1:0]  i_out_id
);
    // a stalled report stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("report dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_peak) && $stable(i_out_flag) && $stable(i_out_id))
        else $error("report payload changed while stalled");

    // flagged window: peak is nonzero, being at least the filtered value that crossed the limit
    a_flag_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_flag |-> i_out_peak != '0)
        else $error("impact flagged with zero peak");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("report offered right after reset");

    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready right after reset");
endmodule

bind impact_magnitude_window_detector imwd_checker u_imwd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_report.valid),
    .i_out_ready (o_report.ready),
    .i_out_peak  (o_report.peak_magnitude),
    .i_out_flag  (o_report.impact_flag),
    .i_out_id    (o_report.source_id)
);
`default_nettype wire
